// ===== rtl/message_frame_parser_macros.svh =====
// Assertion macros shared by the message frame parser checkers.
`ifndef MESSAGE_FRAME_PARSER_MACROS_SVH
`define MESSAGE_FRAME_PARSER_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define MFP_ASSERT_CR(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define MFP_ASSERT(label, prop, msg) `MFP_ASSERT_CR(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/mfp_pkg.sv =====
// Shared types and constants of the message frame parser.
`timescale 1ns / 1ps

package mfp_pkg;

  typedef enum logic [2:0] {
    KIND_PREFIX     = 3'd0,
    KIND_KEYLEN     = 3'd1,
    KIND_KEY        = 3'd2,
    KIND_DATALEN    = 3'd3,
    KIND_DATA       = 3'd4,
    KIND_BADPREFIX  = 3'd5,
    KIND_TIMEOUT    = 3'd6
  } kind_e;

  localparam logic [7:0] CHAR_GET    = 8'h67;  // 'g'
  localparam logic [7:0] CHAR_SET    = 8'h73;  // 's'
  localparam logic [7:0] CHAR_RETURN = 8'h72;  // 'r'
  localparam logic [7:0] CHAR_DEBUG  = 8'h64;  // 'd'

  localparam logic [7:0] TIMEOUT_RESET = 8'd100;

endpackage

// ===== rtl/message_frame_parser.sv =====
// Receive-side message framer: tags each byte with its role and position.
`timescale 1ns / 1ps

// Takes one item per cycle while no result waits downstream. An accepted
// item sits in an input register, is decoded against the framer state, and
// its result (if any) lands in the output register, from which it is
// offered. One item is still accepted while a result waits downstream.
// Idle ticks with no result never block. timeout_ticks (reset 100) is the
// number of idle ticks allowed inside a message; the next one aborts it.
module message_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,      // timeout_ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // rx_byte
  input  logic        s_axis_tuser,    // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // value [7:0], position [15:8]
  output logic [2:0]  m_axis_tuser,    // kind
  output logic        m_axis_tlast
);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_KEYLEN  = 5'b00010,
    PH_KEY     = 5'b00100,
    PH_DATALEN = 5'b01000,
    PH_DATA    = 5'b10000
  } phase_e;

  logic        timeout_hit;
  logic [7:0]  timeout_ticks_q;

  logic        in_v_q;
  logic        in_tick_q;
  logic [7:0]  in_byte_q;

  phase_e      phase_q, phase_d;
  logic        has_data_q, has_data_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  idle_q, idle_d;

  logic          res_v;
  mfp_pkg::kind_e res_kind;
  logic [7:0]    res_val;
  logic [7:0]    res_pos;
  logic          res_last;

  logic          out_v_q;
  mfp_pkg::kind_e out_kind_q;
  logic [7:0]    out_val_q;
  logic [7:0]    out_pos_q;
  logic          out_last_q;

  logic adv;
  logic accept;
  logic [7:0] left_dec;

  assign adv           = in_v_q && (!out_v_q || m_axis_tready || !res_v);
  assign s_axis_tready = !in_v_q || adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign left_dec      = left_q - 8'd1;

  always_comb begin
    phase_d     = phase_q;
    has_data_d  = has_data_q;
    left_d      = left_q;
    pos_d       = pos_q;
    idle_d      = idle_q;
    res_v       = 1'b0;
    res_kind    = mfp_pkg::KIND_PREFIX;
    res_val     = in_byte_q;
    res_pos     = 8'd0;
    res_last    = 1'b0;
    timeout_hit = (idle_q >= timeout_ticks_q);

    if (in_tick_q) begin
      if (phase_q != PH_IDLE) begin
        if (timeout_hit) begin
          phase_d    = PH_IDLE;
          has_data_d = 1'b0;
          left_d     = 8'd0;
          pos_d      = 8'd0;
          idle_d     = 8'd0;
          res_v      = 1'b1;
          res_kind   = mfp_pkg::KIND_TIMEOUT;
          res_val    = 8'd0;
        end else begin
          idle_d = idle_q + 8'd1;
        end
      end
    end else begin
      idle_d = 8'd0;
      res_v  = 1'b1;
      unique case (phase_q)
        PH_IDLE: begin
          if (in_byte_q == mfp_pkg::CHAR_GET || in_byte_q == mfp_pkg::CHAR_SET ||
              in_byte_q == mfp_pkg::CHAR_RETURN || in_byte_q == mfp_pkg::CHAR_DEBUG) begin
            has_data_d = (in_byte_q != mfp_pkg::CHAR_GET);
            phase_d    = PH_KEYLEN;
            res_kind   = mfp_pkg::KIND_PREFIX;
          end else begin
            res_kind = mfp_pkg::KIND_BADPREFIX;
            res_val  = 8'd0;
          end
        end
        PH_KEYLEN: begin
          res_kind = mfp_pkg::KIND_KEYLEN;
          pos_d    = 8'd0;
          if (in_byte_q == 8'd0) begin
            left_d = 8'd0;
            if (has_data_q) begin
              phase_d = PH_DATALEN;
            end else begin
              phase_d    = PH_IDLE;
              has_data_d = 1'b0;
              res_last   = 1'b1;
            end
          end else begin
            left_d  = in_byte_q;
            phase_d = PH_KEY;
          end
        end
        PH_KEY: begin
          res_kind = mfp_pkg::KIND_KEY;
          res_pos  = pos_q;
          pos_d    = pos_q + 8'd1;
          left_d   = left_dec;
          if (left_dec == 8'd0) begin
            pos_d = 8'd0;
            if (has_data_q) begin
              phase_d = PH_DATALEN;
            end else begin
              phase_d    = PH_IDLE;
              has_data_d = 1'b0;
              res_last   = 1'b1;
            end
          end
        end
        PH_DATALEN: begin
          res_kind = mfp_pkg::KIND_DATALEN;
          pos_d    = 8'd0;
          if (in_byte_q == 8'd0) begin
            phase_d    = PH_IDLE;
            has_data_d = 1'b0;
            left_d     = 8'd0;
            res_last   = 1'b1;
          end else begin
            left_d  = in_byte_q;
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          res_kind = mfp_pkg::KIND_DATA;
          res_pos  = pos_q;
          pos_d    = pos_q + 8'd1;
          left_d   = left_dec;
          if (left_dec == 8'd0) begin
            phase_d    = PH_IDLE;
            has_data_d = 1'b0;
            pos_d      = 8'd0;
            res_last   = 1'b1;
          end
        end
        default: begin
          phase_d    = PH_IDLE;
          has_data_d = 1'b0;
          left_d     = 8'd0;
          pos_d      = 8'd0;
          res_v      = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q <= mfp_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_ticks_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (accept) begin
      in_v_q <= 1'b1;
    end else if (adv) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_tick_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      has_data_q <= 1'b0;
      left_q     <= 8'd0;
      pos_q      <= 8'd0;
      idle_q     <= 8'd0;
    end else if (adv) begin
      phase_q    <= phase_d;
      has_data_q <= has_data_d;
      left_q     <= left_d;
      pos_q      <= pos_d;
      idle_q     <= idle_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv && res_v) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_v) begin
      out_kind_q <= res_kind;
      out_val_q  <= res_val;
      out_pos_q  <= res_pos;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_pos_q, out_val_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/mfp_checker.sv =====
// Port-level checker for the message frame parser, bound to the top level.
`timescale 1ns / 1ps
`include "message_frame_parser_macros.svh"

module mfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic        out_stall;
  logic        err_out;
  logic        hdr_out;
  logic [19:0] m_item;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign err_out   = m_axis_tvalid &&
                     ((m_axis_tuser == mfp_pkg::KIND_TIMEOUT) ||
                      (m_axis_tuser == mfp_pkg::KIND_BADPREFIX));
  assign hdr_out   = m_axis_tvalid &&
                     ((m_axis_tuser == mfp_pkg::KIND_PREFIX) ||
                      (m_axis_tuser == mfp_pkg::KIND_KEYLEN) ||
                      (m_axis_tuser == mfp_pkg::KIND_DATALEN));
  assign m_item    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  `MFP_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_item), "held result changed")
  `MFP_ASSERT(a_err_clean, err_out |-> {m_axis_tlast, m_axis_tdata} == '0, "error not clean")
  `MFP_ASSERT(a_hdr_pos, hdr_out |-> m_axis_tdata[15:8] == 8'd0, "header has a position")
  `MFP_ASSERT(a_stall_cause, !s_axis_tready |-> out_stall, "input stalled without output stall")

endmodule

bind message_frame_parser mfp_checker u_mfp_checker (.*);
